### rtl/core/memory_to_memory_cpu_step_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the memory-to-memory CPU step block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEMORY_TO_MEMORY_CPU_STEP_DEFINES_SVH
`define MEMORY_TO_MEMORY_CPU_STEP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define M2M_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define M2M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/m2mcpu_pkg.sv
// ----------------------------------------------------------------------------
// m2mcpu_pkg
// Opcodes, special addresses, event codes and the ALU function.
// ----------------------------------------------------------------------------
`default_nettype none

package m2mcpu_pkg;

  localparam logic [15:0] OP_MOV   = 16'd0;
  localparam logic [15:0] OP_ADD   = 16'd1;
  localparam logic [15:0] OP_XOR   = 16'd2;
  localparam logic [15:0] OP_AND   = 16'd3;
  localparam logic [15:0] OP_SHIFT = 16'd4;
  localparam logic [15:0] OP_MIF   = 16'd5;

  localparam logic [15:0] ADDR_PC   = 16'd0;
  localparam logic [15:0] ADDR_IO   = 16'd1;
  localparam logic [15:0] ADDR_DBG  = 16'd2;
  localparam logic [15:0] ADDR_HALT = 16'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_PORT  = 2'd1;
  localparam logic [1:0] EV_DEBUG = 2'd2;
  localparam logic [1:0] EV_HALT  = 2'd3;

  localparam logic       CMD_LOAD = 1'b0;

  typedef struct packed {
    logic [15:0] val;
    logic        flag;
  } alu_res_t;

  // x is the [arg1] operand, y the [arg2] operand.
  function automatic alu_res_t alu_exec(logic [15:0] op, logic [15:0] x,
                                        logic [15:0] y, logic flag_in);
    alu_res_t    res;
    logic [16:0] sum;
    logic [15:0] mag;
    res.val  = x;
    res.flag = flag_in;
    sum      = {1'b0, x} + {1'b0, y};
    mag      = 16'd0 - x;
    case (op)
      OP_ADD: begin
        res.val  = sum[15:0];
        res.flag = sum[16];
      end
      OP_XOR: res.val = x ^ y;
      OP_AND: res.val = x & y;
      OP_SHIFT: begin
        if ((x != 16'd0) && !x[15]) begin
          res.flag = y[15];
          res.val  = (x >= 16'd16) ? 16'd0 : (y << x[3:0]);
        end else begin
          res.flag = y[0];
          res.val  = (mag >= 16'd16) ? 16'd0 : (y >> mag[3:0]);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/memory_to_memory_cpu_step.sv
// ----------------------------------------------------------------------------
// memory_to_memory_cpu_step
// 16-bit memory-to-memory CPU, one load or one instruction per command.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the command is done, and exactly one result follows on out_* with
// out_valid high for a single cycle. The receiver cannot stall: sample the
// result in the cycle out_valid is high. All work goes through one
// single-port word RAM, one access per cycle, under a small sequencer; each
// RAM read takes an address state and a data state (ST_ACC, ST_DATA). With
// a power-of-two MEM_DEPTH a load is one RAM write and a wrap-up, a step
// while halted only the wrap-up, and a full instruction is three fetches, a
// decode, up to two operand reads, a second-operand decode, an execute, a
// write and a wrap-up; operand reads of address 0 skip the RAM.
// For any other MEM_DEPTH each RAM access first reduces its address modulo
// the depth by restoring subtraction in ST_RED. After reset the RAM is
// cleared one word per cycle, with busy high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "memory_to_memory_cpu_step_defines.svh"

module memory_to_memory_cpu_step #(
  parameter int MEM_DEPTH = 16384,
  parameter int RESET_PC  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [13:0] in_load_address,
  input  wire logic [15:0] in_load_data,
  // result channel
  output logic             out_valid,
  output logic [1:0]       out_event_kind,
  output logic [15:0]      out_out_word,
  output logic [15:0]      out_pc_value,
  output logic             out_flag_value,
  output logic             out_halted
);

  import m2mcpu_pkg::*;

  // RAM index width and modulo reduction step count.
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int POW2      = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0) ? 1 : 0;
  localparam int RED_STEPS = 17 - AW;
  localparam int RCW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR,  // post-reset RAM wipe
    ST_IDLE,
    ST_RED,    // address modulo reduction, one subtract per cycle
    ST_ACC,    // RAM access issue
    ST_DATA,   // RAM read data back
    ST_DEC,    // decode, first operand source
    ST_YDEC,   // second operand source
    ST_EXEC,   // ALU and special-address side effects
    ST_FIN     // result goes out next cycle
  } state_t;

  // Which access the current address job belongs to.
  typedef enum logic [2:0] {
    PH_OP,
    PH_A1,
    PH_A2,
    PH_X,
    PH_Y,
    PH_WR,
    PH_LD
  } phase_t;

  state_t      st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [RCW-1:0] red_cnt_r, red_cnt_nxt;
  logic [15:0] ra_r, ra_nxt;        // address under reduction / in use
  logic [15:0] pc_r, pc_nxt;
  logic        flag_r, flag_nxt;
  logic        run_r, run_nxt;
  logic [15:0] op_r, op_nxt;
  logic [15:0] a1_r, a1_nxt;
  logic [15:0] a2_r, a2_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [15:0] wval_r, wval_nxt;
  logic [1:0]  ev_kind_r, ev_kind_nxt;
  logic [15:0] ev_word_r, ev_word_nxt;

  logic        out_valid_nxt;
  logic [1:0]  out_event_kind_nxt;
  logic [15:0] out_out_word_nxt;
  logic [15:0] out_pc_value_nxt;
  logic        out_flag_value_nxt;
  logic        out_halted_nxt;

  // address job launch
  logic        job_go;
  logic [15:0] job_addr;
  phase_t      job_ph;

  logic [16:0] red_sub;
  alu_res_t    alu_res;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  m2mcpu_ram #(
    .WIDTH (16),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy    = (st_r != ST_IDLE);
  assign red_sub = 17'(MEM_DEPTH) << red_cnt_r;
  assign alu_res = alu_exec(op_r, x_r, y_r, flag_r);

  always_comb begin
    st_nxt      = st_r;
    ph_nxt      = ph_r;
    clr_cnt_nxt = clr_cnt_r;
    red_cnt_nxt = red_cnt_r;
    ra_nxt      = ra_r;
    pc_nxt      = pc_r;
    flag_nxt    = flag_r;
    run_nxt     = run_r;
    op_nxt      = op_r;
    a1_nxt      = a1_r;
    a2_nxt      = a2_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    wval_nxt    = wval_r;
    ev_kind_nxt = ev_kind_r;
    ev_word_nxt = ev_word_r;

    out_valid_nxt      = 1'b0;
    out_event_kind_nxt = out_event_kind;
    out_out_word_nxt   = out_out_word;
    out_pc_value_nxt   = out_pc_value;
    out_flag_value_nxt = out_flag_value;
    out_halted_nxt     = out_halted;

    job_go   = 1'b0;
    job_addr = ra_r;
    job_ph   = ph_r;

    ram_we    = 1'b0;
    ram_addr  = ra_r[AW-1:0];
    ram_wdata = wval_r;

    unique case (st_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = 16'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          ev_kind_nxt = EV_NONE;
          ev_word_nxt = 16'd0;
          if (in_command == CMD_LOAD) begin
            wval_nxt = in_load_data;
            job_go   = 1'b1;
            job_addr = 16'(in_load_address);
            job_ph   = PH_LD;
          end else if (run_r) begin
            // fetch opcode; pc moves past each word as it is fetched
            job_go   = 1'b1;
            job_addr = pc_r;
            job_ph   = PH_OP;
            pc_nxt   = pc_r + 16'd1;
          end else begin
            st_nxt = ST_FIN;
          end
        end
      end

      ST_RED: begin
        if ({1'b0, ra_r} >= red_sub) begin
          ra_nxt = ra_r - red_sub[15:0];
        end
        red_cnt_nxt = red_cnt_r - 1'b1;
        if (red_cnt_r == '0) begin
          st_nxt = ST_ACC;
        end
      end

      ST_ACC: begin
        if ((ph_r == PH_WR) || (ph_r == PH_LD)) begin
          ram_we = 1'b1;
          st_nxt = ST_FIN;
        end else begin
          st_nxt = ST_DATA;
        end
      end

      ST_DATA: begin
        unique case (ph_r)
          PH_OP: begin
            op_nxt   = ram_rdata;
            job_go   = 1'b1;
            job_addr = pc_r;
            job_ph   = PH_A1;
            pc_nxt   = pc_r + 16'd1;
          end
          PH_A1: begin
            a1_nxt   = ram_rdata;
            job_go   = 1'b1;
            job_addr = pc_r;
            job_ph   = PH_A2;
            pc_nxt   = pc_r + 16'd1;
          end
          PH_A2: begin
            a2_nxt = ram_rdata;
            st_nxt = ST_DEC;
          end
          PH_X: begin
            x_nxt  = ram_rdata;
            st_nxt = ST_YDEC;
          end
          PH_Y: begin
            y_nxt  = ram_rdata;
            st_nxt = ST_EXEC;
          end
          default: st_nxt = ST_FIN;
        endcase
      end

      ST_DEC: begin
        // unknown opcode, or MIF with the flag clear: nothing happens
        if ((op_r > OP_MIF) || ((op_r == OP_MIF) && !flag_r)) begin
          st_nxt = ST_FIN;
        end else if (a1_r == ADDR_PC) begin
          x_nxt  = pc_r;
          st_nxt = ST_YDEC;
        end else begin
          job_go   = 1'b1;
          job_addr = a1_r;
          job_ph   = PH_X;
        end
      end

      ST_YDEC: begin
        if ((op_r == OP_MOV) || (op_r == OP_MIF)) begin
          st_nxt = ST_EXEC;
        end else if (a2_r == ADDR_PC) begin
          y_nxt  = pc_r;
          st_nxt = ST_EXEC;
        end else begin
          job_go   = 1'b1;
          job_addr = a2_r;
          job_ph   = PH_Y;
        end
      end

      ST_EXEC: begin
        wval_nxt = alu_res.val;
        flag_nxt = alu_res.flag;
        job_go   = 1'b1;
        job_addr = a2_r;
        job_ph   = PH_WR;
        // special addresses act on the machine; the word still lands in RAM
        case (a2_r)
          ADDR_PC: pc_nxt = alu_res.val;
          ADDR_IO: begin
            ev_kind_nxt = EV_PORT;
            ev_word_nxt = {8'h00, alu_res.val[7:0]};
          end
          ADDR_DBG: begin
            ev_kind_nxt = EV_DEBUG;
            ev_word_nxt = alu_res.val;
          end
          ADDR_HALT: begin
            ev_kind_nxt = EV_HALT;
            ev_word_nxt = 16'd0;
            run_nxt     = 1'b0;
          end
          default: ;
        endcase
      end

      ST_FIN: begin
        out_valid_nxt      = 1'b1;
        out_event_kind_nxt = ev_kind_r;
        out_out_word_nxt   = ev_word_r;
        out_pc_value_nxt   = pc_r;
        out_flag_value_nxt = flag_r;
        out_halted_nxt     = !run_r;
        st_nxt             = ST_IDLE;
      end

      default: st_nxt = ST_IDLE;
    endcase

    if (job_go) begin
      ra_nxt      = job_addr;
      ph_nxt      = job_ph;
      red_cnt_nxt = RCW'(RED_STEPS - 1);
      st_nxt      = (POW2 != 0) ? ST_ACC : ST_RED;
    end
  end

  always_ff @(posedge clk) begin
    // datapath, no reset needed
    ph_nxt_hold: begin
      ph_r           <= ph_nxt;
      red_cnt_r      <= red_cnt_nxt;
      ra_r           <= ra_nxt;
      op_r           <= op_nxt;
      a1_r           <= a1_nxt;
      a2_r           <= a2_nxt;
      x_r            <= x_nxt;
      y_r            <= y_nxt;
      wval_r         <= wval_nxt;
      ev_kind_r      <= ev_kind_nxt;
      ev_word_r      <= ev_word_nxt;
      out_event_kind <= out_event_kind_nxt;
      out_out_word   <= out_out_word_nxt;
      out_pc_value   <= out_pc_value_nxt;
      out_flag_value <= out_flag_value_nxt;
      out_halted     <= out_halted_nxt;
    end
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
      pc_r      <= 16'(RESET_PC);
      flag_r    <= 1'b0;
      run_r     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r      <= pc_nxt;
      flag_r    <= flag_nxt;
      run_r     <= run_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  // A taken command always makes the block busy in the next cycle.
  `M2M_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command taken but not busy")
  // Every command leaves idle for at least ST_FIN before its strobe, so strobes never touch.
  `M2M_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe on two cycles")
  // The result is issued as the sequencer returns to idle.
  `M2M_ASSERT_NOW(a_result_idle, out_valid, !busy, "result while sequencer busy")
  // A halt write must report the halted state with it.
  `M2M_ASSERT_NOW(a_halt_event, out_valid && (out_event_kind == EV_HALT), out_halted,
                  "halt event without halted status")
  // Only reset brings the machine back from halt.
  `M2M_ASSERT_NEXT(a_halt_sticky, !run_r, !run_r, "machine left halt without reset")

endmodule

`default_nettype wire

### rtl/core/m2mcpu_ram.sv
// ----------------------------------------------------------------------------
// m2mcpu_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module m2mcpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### tb/sv/tb_memory_to_memory_cpu_step.sv
// ----------------------------------------------------------------------------
// tb_memory_to_memory_cpu_step
// Self-checking bench for the 16-bit memory-to-memory CPU step block. A short
// table of hand-written commands (loads plus one program using every opcode)
// runs first. A long random run follows, built mostly from whole instructions
// placed at the current program counter, mixed with bare steps and stray loads.
// It halts the machine near the end. Every result is compared against an
// in-bench CPU model advanced at each accepted command, or a typed row's value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_memory_to_memory_cpu_step;
  import m2mcpu_pkg::*;

  localparam int          MEM_WORDS      = 16384;
  localparam int          BOOT_PC        = 256;
  localparam int          ITEM_TARGET    = 1050;
  localparam int          WATCHDOG_LIMIT = 50000;  // covers the post-reset RAM clear
  localparam int          SETTLE_CYCLES  = 32;
  localparam logic        CMD_STEP       = 1'b1;
  localparam logic [15:0] DATA_BASE      = 16'h2000;

  // One result transfer, in port order.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [15:0] pc;
    logic        flag;
    logic        halted;
  } cpu_result_t;

  // One row of the directed table. Rows with typed set carry their own
  // expected result; the others are checked against the model.
  typedef struct packed {
    logic        cmd;
    logic [13:0] addr;
    logic [15:0] data;
    logic        typed;
    cpu_result_t res;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        in_command      = 1'b0;
  logic [13:0] in_load_address = '0;
  logic [15:0] in_load_data    = '0;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_event_kind;
  logic [15:0] out_out_word;
  logic [15:0] out_pc_value;
  logic        out_flag_value;
  logic        out_halted;

  always #4 clk = ~clk;

  memory_to_memory_cpu_step #(
    .MEM_DEPTH(MEM_WORDS),
    .RESET_PC (BOOT_PC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_load_address(in_load_address),
    .in_load_data   (in_load_data),
    .out_valid      (out_valid),
    .out_event_kind (out_event_kind),
    .out_out_word   (out_out_word),
    .out_pc_value   (out_pc_value),
    .out_flag_value (out_flag_value),
    .out_halted     (out_halted)
  );

  // --------------------------------------------------------------------------
  // CPU model: shadow copy of memory and machine state
  // --------------------------------------------------------------------------
  logic [15:0] shadow_mem [MEM_WORDS];
  logic [15:0] shadow_pc;
  logic        shadow_flag;
  logic        shadow_running;

  cpu_result_t expected_results [$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          burst_left     = 0;
  int          idle_cycles    = 0;
  bit          halt_allowed   = 1'b0;

  function automatic logic [13:0] word_index(input logic [15:0] addr);
    return 14'(addr % MEM_WORDS);
  endfunction

  // Operand read: raw address 0 is the (already advanced) pc, the rest is RAM.
  function automatic logic [15:0] operand_read(input logic [15:0] addr);
    return (addr == ADDR_PC) ? shadow_pc : shadow_mem[word_index(addr)];
  endfunction

  function automatic logic [15:0] fetch_word();
    logic [15:0] w;
    w         = shadow_mem[word_index(shadow_pc)];
    shadow_pc = shadow_pc + 16'd1;
    return w;
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic cpu_result_t cpu_command(input logic cmd, input logic [13:0] laddr,
                                              input logic [15:0] ldata);
    cpu_result_t r;
    logic [15:0] op, src, dst, x, y, wval, mag;
    logic [16:0] total;
    logic        do_write;
    r.kind = EV_NONE;
    r.word = '0;
    if (cmd == CMD_LOAD) begin
      shadow_mem[laddr] = ldata;
    end else if (shadow_running) begin
      op       = fetch_word();
      src      = fetch_word();
      dst      = fetch_word();
      x        = operand_read(src);
      y        = operand_read(dst);
      wval     = x;
      do_write = 1'b1;
      case (op)
        OP_MOV: wval = x;
        OP_ADD: begin
          total       = {1'b0, x} + {1'b0, y};
          wval        = total[15:0];
          shadow_flag = total[16];
        end
        OP_XOR: wval = x ^ y;
        OP_AND: wval = x & y;
        OP_SHIFT: begin
          // positive amount: left, flag from msb; zero/negative: right, flag from lsb
          if (x != 16'd0 && !x[15]) begin
            shadow_flag = y[15];
            wval        = (x >= 16'd16) ? 16'd0 : (y << x);
          end else begin
            mag         = 16'd0 - x;
            shadow_flag = y[0];
            wval        = (mag >= 16'd16) ? 16'd0 : (y >> mag);
          end
        end
        OP_MIF:  do_write = shadow_flag;
        default: do_write = 1'b0;
      endcase
      if (do_write) begin
        shadow_mem[word_index(dst)] = wval;
        case (dst)
          ADDR_PC:    shadow_pc = wval;
          ADDR_IO: begin
            r.kind = EV_PORT;
            r.word = {8'h00, wval[7:0]};
          end
          ADDR_DBG: begin
            r.kind = EV_DEBUG;
            r.word = wval;
          end
          ADDR_HALT: begin
            r.kind         = EV_HALT;
            shadow_running = 1'b0;
          end
          default: ;
        endcase
      end
    end
    r.pc     = shadow_pc;
    r.flag   = shadow_flag;
    r.halted = !shadow_running;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: one small program exercising every opcode
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [26] = '{
    // top word set to all ones, load reports reset state
    '{CMD_LOAD, 14'h3FFF, 16'hFFFF, 1'b1, '{EV_NONE, 16'h0000, 16'd256, 1'b0, 1'b0}},
    // MOV [3FFF] -> debug address
    '{CMD_LOAD, 14'h0100, OP_MOV,     1'b0, '0},
    '{CMD_LOAD, 14'h0101, 16'h3FFF,   1'b0, '0},
    '{CMD_LOAD, 14'h0102, ADDR_DBG,   1'b0, '0},
    '{CMD_STEP, 14'h0000, 16'h0000, 1'b1, '{EV_DEBUG, 16'hFFFF, 16'd259, 1'b0, 1'b0}},
    // ADD max + max: carry out sets the flag
    '{CMD_LOAD, 14'h0103, OP_ADD,   1'b0, '0},
    '{CMD_LOAD, 14'h0104, 16'h3FFF, 1'b0, '0},
    '{CMD_LOAD, 14'h0105, 16'h3FFF, 1'b0, '0},
    '{CMD_STEP, 14'h0000, 16'h0000, 1'b0, '0},
    // MIF with flag set -> port gets the low byte of FFFE
    '{CMD_LOAD, 14'h0106, OP_MIF,    1'b0, '0},
    '{CMD_LOAD, 14'h0107, 16'h3FFF,  1'b0, '0},
    '{CMD_LOAD, 14'h0108, ADDR_IO,   1'b0, '0},
    '{CMD_STEP, 14'h0000, 16'h0000, 1'b1, '{EV_PORT, 16'h00FE, 16'd265, 1'b1, 1'b0}},
    // SHIFT by a negative amount (-2): right shift, flag from lsb
    '{CMD_LOAD, 14'h0109, OP_SHIFT, 1'b0, '0},
    '{CMD_LOAD, 14'h010A, 16'h3FFF, 1'b0, '0},
    '{CMD_LOAD, 14'h010B, 16'h3FFF, 1'b0, '0},
    '{CMD_STEP, 14'h0000, 16'h0000, 1'b0, '0},
    // XOR with the pc read through address 0
    '{CMD_LOAD, 14'h010C, OP_XOR,   1'b0, '0},
    '{CMD_LOAD, 14'h010D, ADDR_PC,  1'b0, '0},
    '{CMD_LOAD, 14'h010E, 16'h3FFF, 1'b0, '0},
    '{CMD_STEP, 14'h0000, 16'h0000, 1'b0, '0},
    // AND with a destination that aliases 3FFF through the address wrap
    '{CMD_LOAD, 14'h010F, OP_AND,   1'b0, '0},
    '{CMD_LOAD, 14'h0110, 16'h3FFF, 1'b0, '0},
    '{CMD_LOAD, 14'h0111, 16'h7FFF, 1'b0, '0},
    '{CMD_STEP, 14'h0000, 16'h0000, 1'b0, '0},
    // all-ones opcode loaded at 0x112; the step that runs it (doing nothing) follows the table
    '{CMD_LOAD, 14'h0112, 16'hFFFF, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------
  // Sender runs in bursts; a burst ends with a random gap (sometimes none).
  // The command transfers on the edge where start is high and busy is low,
  // and the model is advanced right there.
  task automatic send_cmd(input logic cmd, input logic [13:0] addr, input logic [15:0] data,
                          input logic use_typed, input cpu_result_t typed_res);
    int          pause;
    cpu_result_t predicted;
    if (burst_left == 0) begin
      pause      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (pause != 0) begin
        start <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    start           <= 1'b1;
    in_command      <= cmd;
    in_load_address <= addr;
    in_load_data    <= data;
    do @(posedge clk); while (busy);
    predicted = cpu_command(cmd, addr, data);
    expected_results.push_back(use_typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Hold off until every outstanding result is back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Random value pickers
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Shift amounts: zero, small and large positive, small and large negative.
  function automatic logic [15:0] pick_shift();
    case ($urandom_range(0, 6))
      0:       return 16'h0000;
      1:       return 16'($urandom_range(1, 15));
      2:       return 16'($urandom_range(16, 16'h7FFF));
      3:       return 16'(32'h10000 - $urandom_range(1, 15));
      4:       return 16'hFFF0;
      5:       return 16'($urandom_range(16'h8000, 16'hFFEF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_opcode();
    if ($urandom_range(0, 99) < 88) return 16'($urandom_range(OP_MOV, OP_MIF));
    return 16'($urandom);
  endfunction

  // Operand addresses: specials, wrap aliases of the low words, a small data
  // pool (so results feed later instructions), and anything at all. The halt
  // address is kept off destinations until the closing phase.
  function automatic logic [15:0] pick_address(input bit as_dest);
    int          roll;
    logic [15:0] a;
    roll = $urandom_range(0, 99);
    if (roll < 12)
      a = 16'($urandom_range(ADDR_PC, ADDR_HALT));
    else if (roll < 20)
      a = {2'($urandom_range(1, 3)), 14'($urandom_range(0, 3))};
    else if (roll < 75)
      a = DATA_BASE + 16'($urandom_range(0, 15));
    else
      a = 16'($urandom);
    if (as_dest && !halt_allowed && a == ADDR_HALT) a = ADDR_DBG;
    return a;
  endfunction

  // Optionally seed the operands, write the instruction at the current pc
  // (with wrap) and step it.
  task automatic run_instruction(input logic [15:0] op, input logic [15:0] src,
                                 input logic [15:0] dst);
    logic [15:0] at;
    if ($urandom_range(0, 9) < 6)
      send_cmd(CMD_LOAD, word_index(src), (op == OP_SHIFT) ? pick_shift() : pick_word(),
               1'b0, '0);
    if ($urandom_range(0, 9) < 6)
      send_cmd(CMD_LOAD, word_index(dst), pick_word(), 1'b0, '0);
    at = shadow_pc;
    send_cmd(CMD_LOAD, word_index(at), op, 1'b0, '0);
    at = at + 16'd1;
    send_cmd(CMD_LOAD, word_index(at), src, 1'b0, '0);
    at = at + 16'd1;
    send_cmd(CMD_LOAD, word_index(at), dst, 1'b0, '0);
    send_cmd(CMD_STEP, 14'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: the receiver never stalls, so every out_valid is a transfer
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input cpu_result_t want,
                                 input cpu_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: exp kind=%0d word=%h pc=%h flag=%b halted=%b | got kind=%0d word=%h pc=%h flag=%b halted=%b",
               $realtime, what, want.kind, want.word, want.pc, want.flag, want.halted,
               got.kind, got.word, got.pc, got.flag, got.halted);
  endtask

  always @(posedge clk) begin : result_check
    cpu_result_t got;
    cpu_result_t want;
    if (rst_n && out_valid) begin
      got = {out_event_kind, out_out_word, out_pc_value, out_flag_value, out_halted};
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)     report_mismatch("event kind", want, got);
        else if (got.word !== want.word) report_mismatch("output word", want, got);
        else if (got.pc !== want.pc)     report_mismatch("pc", want, got);
        else if (got.flag !== want.flag) report_mismatch("flag", want, got);
        else if (got.halted !== want.halted) report_mismatch("halted", want, got);
      end
    end
  end

  // Watchdog: any command or result transfer resets it.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int roll;
    for (int i = 0; i < MEM_WORDS; i++) shadow_mem[i] = '0;
    shadow_pc      = 16'(BOOT_PC);
    shadow_flag    = 1'b0;
    shadow_running = 1'b1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed program, then one step that runs the all-ones opcode at 0x112
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].data,
               directed_rows[i].typed, directed_rows[i].res);
    send_cmd(CMD_STEP, 14'h3FFF, 16'hFFFF, 1'b1,
             '{EV_NONE, 16'h0000, 16'd277, 1'b0, 1'b0});

    // sender holds off until the pipe is empty
    drain_results();

    // main random run: mostly complete instructions
    while (items_sent < ITEM_TARGET - 24) begin
      roll = $urandom_range(0, 99);
      if (roll < 66)
        run_instruction(pick_opcode(), pick_address(1'b0), pick_address(1'b1));
      else if (roll < 80)
        repeat ($urandom_range(1, 4))
          send_cmd(CMD_STEP, 14'($urandom), 16'($urandom), 1'b0, '0);
      else if (roll < 97)
        repeat ($urandom_range(1, 3))
          send_cmd(CMD_LOAD, 14'($urandom), 16'($urandom), 1'b0, '0);
      else
        drain_results();
    end

    // closing phase: halt the machine, then steps must do nothing
    halt_allowed = 1'b1;
    run_instruction(16'($urandom_range(OP_MOV, OP_SHIFT)), pick_address(1'b0), ADDR_HALT);
    while (items_sent < ITEM_TARGET)
      send_cmd(logic'($urandom_range(0, 1)), 14'($urandom), 16'($urandom), 1'b0, '0);

    // wait for the tail, then let the bench settle for stray results
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### memory_to_memory_cpu_step.f
+incdir+rtl/core
rtl/core/m2mcpu_pkg.sv
rtl/core/m2mcpu_ram.sv
rtl/core/memory_to_memory_cpu_step.sv
tb/sv/tb_memory_to_memory_cpu_step.sv
